[rtl/core/bats_pkg.sv]
// shared types, codes and constants of the batched transfer sender
package bats_pkg;

  localparam int BATCH_MAX = 8;
  localparam int SLOT_AW   = 3;
  localparam int CNT_W     = 4;
  localparam int QDEPTH    = 12;
  localparam int QAW       = 4;

  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_TICK   = 2'd1,
    EV_PAUSE  = 2'd2,
    EV_RESUME = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    RX_NONE  = 2'd0,
    RX_ACK   = 2'd1,
    RX_NACK  = 2'd2,
    RX_OTHER = 2'd3
  } rx_kind_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_DATA  = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_HANDSHAKE  = 4'd1,
    PH_SENDING    = 4'd2,
    PH_WAIT_ACK   = 4'd3,
    PH_RETRANSMIT = 4'd4,
    PH_WAIT_END   = 4'd5,
    PH_PAUSED     = 4'd6,
    PH_DONE       = 4'd7,
    PH_FAILED     = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BUSY     = 3'd1,
    ERR_HS_RETRY = 3'd2,
    ERR_DATA_RTY = 3'd3,
    ERR_END_RTY  = 3'd4,
    ERR_END_NACK = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    CFG_BATCH_SIZE  = 3'd0,
    CFG_TIMEOUT_MS  = 3'd1,
    CFG_MAX_RETRY   = 3'd2,
    CFG_SESS_ID     = 3'd3,
    CFG_CHUNK_TOTAL = 3'd4,
    CFG_CONTROL_SEQ = 3'd5,
    CFG_OK_CODE     = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_MSCAN,
    SQ_TSCAN,
    SQ_CHECK,
    SQ_FILL,
    SQ_DRAIN
  } seq_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [1:0]  rx_kind;
    logic [31:0] rx_session;
    logic [15:0] rx_sequence;
    logic [7:0]  rx_result;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] chunk_index;
    logic [3:0]  session_state;
    logic [2:0]  error_code;
    logic [15:0] acked_count;
    logic [15:0] batch_number;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic               fill;
    logic               ack;
    logic               resend;
    logic               rebase;
    logic [SLOT_AW-1:0] idx;
    logic [15:0]        chunk;
    logic [7:0]         retries;
    logic [31:0]        now;
    logic [CNT_W-1:0]   count;
  } slot_wr_t;

endpackage

[rtl/core/bats_expiry.sv]
// wrapping time compare shared by control and slot timers
module bats_expiry
  import bats_pkg::*;
(
  input  logic [31:0] now,
  input  logic [31:0] sent,
  input  logic [15:0] timeout,
  output logic        expired
);

  logic [31:0] elapsed;
  logic [15:0] eff;

  assign elapsed = now - sent;
  assign eff     = (timeout == 16'd0) ? 16'd1 : timeout;
  assign expired = elapsed > {16'd0, eff};

endmodule

[rtl/core/bats_slots.sv]
// per-slot chunk, ack mark, send time and retry count of the current batch
module bats_slots
  import bats_pkg::*;
(
  input  logic               clk,
  input  slot_wr_t           wr,
  input  logic [SLOT_AW-1:0] rd_idx,
  output logic [15:0]        rd_chunk,
  output logic               rd_acked,
  output logic [31:0]        rd_time,
  output logic [7:0]         rd_retries,
  output logic [BATCH_MAX-1:0] acked_vec
);

  logic [15:0] chunk   [BATCH_MAX];
  logic [31:0] stime   [BATCH_MAX];
  logic [7:0]  retries [BATCH_MAX];
  logic [BATCH_MAX-1:0] acked;

  always_ff @(posedge clk) begin
    if (wr.fill) begin
      chunk[wr.idx]   <= wr.chunk;
      acked[wr.idx]   <= 1'b0;
      retries[wr.idx] <= 8'd0;
      stime[wr.idx]   <= wr.now;
    end
    if (wr.ack) begin
      acked[wr.idx] <= 1'b1;
    end
    if (wr.resend) begin
      retries[wr.idx] <= wr.retries;
      stime[wr.idx]   <= wr.now;
    end
    if (wr.rebase) begin
      for (int i = 0; i < BATCH_MAX; i++) begin
        if ((CNT_W'(i) < wr.count) && !acked[i]) begin
          stime[i] <= wr.now;
        end
      end
    end
  end

  assign rd_chunk   = chunk[rd_idx];
  assign rd_acked   = acked[rd_idx];
  assign rd_time    = stime[rd_idx];
  assign rd_retries = retries[rd_idx];
  assign acked_vec  = acked;

endmodule

[rtl/core/bats_resq.sv]
// queue of frames to send that one request produced
module bats_resq
  import bats_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           push,
  input  logic [1:0]     push_act,
  input  logic [15:0]    push_chunk,
  input  logic [QAW-1:0] rd_idx,
  output logic [1:0]     rd_act,
  output logic [15:0]    rd_chunk,
  output logic [QAW-1:0] count
);

  logic [1:0]  act   [QDEPTH];
  logic [15:0] chunk [QDEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (push && (count < QAW'(QDEPTH))) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !clear && (count < QAW'(QDEPTH))) begin
      act[count]   <= push_act;
      chunk[count] <= push_chunk;
    end
  end

  assign rd_act   = act[rd_idx];
  assign rd_chunk = chunk[rd_idx];

endmodule

[rtl/core/batched_arq_transfer_sender_unit.sv]
// top level of the batched selective-repeat transfer sender
//
// usage:
//   req channel (req_valid/req_ready/req): one event per request, start, tick,
//   pause or resume; a tick carries the time and at most one received answer
//   rsp channel (rsp_valid/rsp_ready/rsp): one response per frame to send,
//   or a single response with action none; all responses of one request carry
//   the session state after that request, and the final one has last set
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready, to be written only while no request is in progress
// timing:
//   a request is latched into a register and executed by a small sequencer that
//   walks the batch slots through one shared timer compare; while awaiting acks a
//   tick scans the slots for the answered chunk and then for an expired timer,
//   a new batch is filled when one is due, then one response goes per cycle while
//   rsp_ready is high. req_ready is low from acceptance until the last response goes
// reset: synchronous rst returns the session to idle and the registers to
//   their defaults; slot contents stay unknown until a batch writes them
// stall: while rsp_ready is low the current response holds and no new
//   request is taken
module batched_arq_transfer_sender_unit
  import bats_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [6:0]  batch_size;
  logic [15:0] timeout_ms;
  logic [7:0]  max_retry;
  logic [31:0] sess_id;
  logic [15:0] chunk_total;
  logic [15:0] control_seq;
  logic [7:0]  ok_code;

  // session state
  seq_t             seq, seq_next;
  req_t             item;
  phase_t           phase, phase_next;
  phase_t           paused_from, paused_from_next;
  logic [15:0]      next_unsent, next_unsent_next;
  logic [CNT_W-1:0] slots_in_batch, slots_in_batch_next;
  logic [7:0]       control_retries, control_retries_next;
  logic [31:0]      control_sent_time, control_sent_time_next;
  logic [15:0]      acked_total, acked_total_next;
  logic [15:0]      batches_started, batches_started_next;
  err_t             last_error, last_error_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [QAW-1:0]   rd, rd_next;

  // slot file and queue hookup
  slot_wr_t             swr;
  logic [15:0]          s_chunk;
  logic                 s_acked;
  logic [31:0]          s_time;
  logic [7:0]           s_retries;
  logic [BATCH_MAX-1:0] acked_vec;
  logic                 q_push;
  logic [1:0]           q_act;
  logic [15:0]          q_chunk;
  logic [1:0]           rd_act;
  logic [15:0]          rd_chunk;
  logic [QAW-1:0]       q_count;

  // decision terms
  logic                 req_fire, rsp_fire, rsp_last;
  logic                 ctl_match, sess_match, is_ok, rx_ack, rx_nack;
  logic                 in_range, hit, expired;
  logic [31:0]          t_sel;
  logic [8:0]           slot_r, ctl_r;
  logic                 slot_fail, ctl_fail;
  logic [BATCH_MAX-1:0] in_batch;
  logic                 all_acked;
  logic [CNT_W-1:0]     bs_eff, batch_cnt;
  logic [15:0]          remaining;
  logic                 ctl_resend;

  assign req_ready = (seq == SQ_IDLE);
  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;
  assign rsp_valid = (seq == SQ_DRAIN);
  assign rsp_fire  = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size  <= 7'd5;
      timeout_ms  <= 16'd1000;
      max_retry   <= 8'd5;
      sess_id     <= 32'd0;
      chunk_total <= 16'd1;
      control_seq <= 16'd65535;
      ok_code     <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BATCH_SIZE:  batch_size  <= cfg_data[6:0];
        CFG_TIMEOUT_MS:  timeout_ms  <= cfg_data[15:0];
        CFG_MAX_RETRY:   max_retry   <= cfg_data[7:0];
        CFG_SESS_ID:     sess_id     <= cfg_data;
        CFG_CHUNK_TOTAL: chunk_total <= cfg_data[15:0];
        CFG_CONTROL_SEQ: control_seq <= cfg_data[15:0];
        CFG_OK_CODE:     ok_code     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bats_slots u_slots (
    .clk        (clk),
    .wr         (swr),
    .rd_idx     (idx[SLOT_AW-1:0]),
    .rd_chunk   (s_chunk),
    .rd_acked   (s_acked),
    .rd_time    (s_time),
    .rd_retries (s_retries),
    .acked_vec  (acked_vec)
  );

  bats_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .clear      (req_fire),
    .push       (q_push),
    .push_act   (q_act),
    .push_chunk (q_chunk),
    .rd_idx     (rd),
    .rd_act     (rd_act),
    .rd_chunk   (rd_chunk),
    .count      (q_count)
  );

  // one timer compare, control timer while executing, else the scanned slot
  assign t_sel = (seq == SQ_EXEC) ? control_sent_time : s_time;

  bats_expiry u_expiry (
    .now     (item.now_ms),
    .sent    (t_sel),
    .timeout (timeout_ms),
    .expired (expired)
  );

  assign rx_ack     = (item.rx_kind == RX_ACK);
  assign rx_nack    = (item.rx_kind == RX_NACK);
  assign sess_match = (item.rx_session == sess_id);
  assign ctl_match  = sess_match && (item.rx_sequence == control_seq);
  assign is_ok      = rx_ack && (item.rx_result == ok_code);
  assign in_range   = (idx < slots_in_batch);
  assign hit        = in_range && !s_acked && (s_chunk == item.rx_sequence);
  assign slot_r     = {1'b0, s_retries} + 9'd1;
  assign slot_fail  = slot_r > {1'b0, max_retry};
  assign ctl_r      = {1'b0, control_retries} + 9'd1;
  assign ctl_fail   = ctl_r > {1'b0, max_retry};

  always_comb begin
    for (int i = 0; i < BATCH_MAX; i++) begin
      in_batch[i] = CNT_W'(i) < slots_in_batch;
    end
  end
  assign all_acked = &(acked_vec | ~in_batch);

  // size of the next batch: configured size clamped, then limited by what is left
  assign bs_eff = (batch_size == 7'd0) ? CNT_W'(1) :
                  (batch_size > 7'(BATCH_MAX)) ? CNT_W'(BATCH_MAX) : batch_size[CNT_W-1:0];
  assign remaining = (chunk_total > next_unsent) ? (chunk_total - next_unsent) : 16'd0;
  assign batch_cnt = (remaining < {{(16-CNT_W){1'b0}}, bs_eff}) ? remaining[CNT_W-1:0]
                                                                : bs_eff;

  // handshake frame resend on nack or timeout, end frame resend on timeout only
  assign ctl_resend = (phase == PH_HANDSHAKE) ?
                      ((rx_nack && ctl_match) || expired) :
                      (!(rx_ack && ctl_match) && !(rx_nack && ctl_match) && expired);

  assign rsp_last = (q_count == '0) || (rd == (q_count - 1'b1));

  // next state of the sequencer
  always_comb begin
    seq_next = seq;
    case (seq)
      SQ_IDLE: begin
        if (req_fire) seq_next = SQ_EXEC;
      end
      SQ_EXEC: begin
        seq_next = SQ_DRAIN;
        if (item.kind == EV_TICK) begin
          if (phase == PH_HANDSHAKE && rx_ack && ctl_match) begin
            seq_next = SQ_FILL;
          end else if (phase == PH_WAIT_ACK) begin
            seq_next = ((rx_ack || rx_nack) && sess_match) ? SQ_MSCAN : SQ_TSCAN;
          end
        end
      end
      SQ_MSCAN: begin
        if (!in_range) begin
          seq_next = SQ_TSCAN;
        end else if (hit) begin
          seq_next = (!is_ok && slot_fail) ? SQ_DRAIN : SQ_TSCAN;
        end
      end
      SQ_TSCAN: begin
        if (!in_range) begin
          seq_next = SQ_CHECK;
        end else if (!s_acked && expired) begin
          seq_next = slot_fail ? SQ_DRAIN : SQ_CHECK;
        end
      end
      SQ_CHECK: begin
        if (all_acked && (next_unsent < chunk_total)) seq_next = SQ_FILL;
        else seq_next = SQ_DRAIN;
      end
      SQ_FILL: begin
        if (idx >= fill_count) seq_next = SQ_DRAIN;
      end
      SQ_DRAIN: begin
        if (rsp_fire && rsp_last) seq_next = SQ_IDLE;
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  // datapath controls and register next values
  always_comb begin
    phase_next             = phase;
    paused_from_next       = paused_from;
    next_unsent_next       = next_unsent;
    slots_in_batch_next    = slots_in_batch;
    control_retries_next   = control_retries;
    control_sent_time_next = control_sent_time;
    acked_total_next       = acked_total;
    batches_started_next   = batches_started;
    last_error_next        = last_error;
    idx_next               = idx;
    fill_count_next        = fill_count;
    rd_next                = rd;
    q_push                 = 1'b0;
    q_act                  = ACT_NONE;
    q_chunk                = 16'd0;
    swr                    = '0;
    swr.idx                = idx[SLOT_AW-1:0];
    swr.now                = item.now_ms;
    swr.count              = slots_in_batch;
    swr.retries            = slot_r[7:0];
    swr.chunk              = next_unsent + {{(16-CNT_W){1'b0}}, idx};

    case (seq)
      SQ_IDLE: begin
        rd_next  = '0;
        idx_next = '0;
      end
      SQ_EXEC: begin
        case (item.kind)
          EV_START: begin
            if (phase != PH_IDLE) begin
              last_error_next = ERR_BUSY;
            end else begin
              next_unsent_next       = 16'd0;
              slots_in_batch_next    = '0;
              acked_total_next       = 16'd0;
              batches_started_next   = 16'd0;
              last_error_next        = ERR_NONE;
              phase_next             = PH_HANDSHAKE;
              control_retries_next   = 8'd0;
              control_sent_time_next = item.now_ms;
              q_push                 = 1'b1;
              q_act                  = ACT_START;
            end
          end
          EV_TICK: begin
            if (phase == PH_HANDSHAKE && rx_ack && ctl_match) begin
              // handshake answered, open the first batch
              fill_count_next      = batch_cnt;
              slots_in_batch_next  = batch_cnt;
              batches_started_next = batches_started + 16'd1;
              phase_next           = PH_WAIT_ACK;
            end else if (phase == PH_WAIT_END && rx_ack && ctl_match) begin
              phase_next = PH_DONE;
            end else if (phase == PH_WAIT_END && rx_nack && ctl_match) begin
              last_error_next = ERR_END_NACK;
              phase_next      = PH_FAILED;
            end else if ((phase == PH_HANDSHAKE || phase == PH_WAIT_END) && ctl_resend) begin
              if (ctl_fail) begin
                last_error_next = (phase == PH_HANDSHAKE) ? ERR_HS_RETRY : ERR_END_RTY;
                phase_next      = PH_FAILED;
              end else begin
                control_retries_next   = ctl_r[7:0];
                control_sent_time_next = item.now_ms;
                q_push                 = 1'b1;
                q_act                  = (phase == PH_HANDSHAKE) ? ACT_START : ACT_END;
              end
            end
          end
          EV_PAUSE: begin
            if (phase inside {PH_SENDING, PH_WAIT_ACK, PH_RETRANSMIT, PH_WAIT_END}) begin
              paused_from_next = phase;
              phase_next       = PH_PAUSED;
            end
          end
          EV_RESUME: begin
            if (phase == PH_PAUSED) begin
              control_sent_time_next = item.now_ms;
              swr.rebase             = 1'b1;
              phase_next             = paused_from;
            end
          end
          default: ;
        endcase
      end
      SQ_MSCAN: begin
        if (!in_range) begin
          idx_next = '0;
        end else if (hit) begin
          idx_next = '0;
          if (is_ok) begin
            swr.ack          = 1'b1;
            acked_total_next = acked_total + 16'd1;
          end else if (slot_fail) begin
            last_error_next = ERR_DATA_RTY;
            phase_next      = PH_FAILED;
          end else begin
            swr.resend = 1'b1;
            q_push     = 1'b1;
            q_act      = ACT_DATA;
            q_chunk    = s_chunk;
            phase_next = PH_WAIT_ACK;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      SQ_TSCAN: begin
        if (in_range && !s_acked && expired) begin
          if (slot_fail) begin
            last_error_next = ERR_DATA_RTY;
            phase_next      = PH_FAILED;
          end else begin
            swr.resend = 1'b1;
            q_push     = 1'b1;
            q_act      = ACT_DATA;
            q_chunk    = s_chunk;
            phase_next = PH_WAIT_ACK;
          end
        end else if (in_range) begin
          idx_next = idx + 1'b1;
        end
      end
      SQ_CHECK: begin
        idx_next = '0;
        if (all_acked) begin
          if (next_unsent >= chunk_total) begin
            // all chunks out, send the end frame
            phase_next             = PH_WAIT_END;
            control_retries_next   = 8'd0;
            control_sent_time_next = item.now_ms;
            q_push                 = 1'b1;
            q_act                  = ACT_END;
          end else begin
            fill_count_next      = batch_cnt;
            slots_in_batch_next  = batch_cnt;
            batches_started_next = batches_started + 16'd1;
            phase_next           = PH_WAIT_ACK;
          end
        end
      end
      SQ_FILL: begin
        if (idx < fill_count) begin
          swr.fill = 1'b1;
          q_push   = 1'b1;
          q_act    = ACT_DATA;
          q_chunk  = swr.chunk;
          idx_next = idx + 1'b1;
        end else begin
          next_unsent_next = next_unsent + {{(16-CNT_W){1'b0}}, fill_count};
        end
      end
      SQ_DRAIN: begin
        if (rsp_fire && !rsp_last) rd_next = rd + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq               <= SQ_IDLE;
      phase             <= PH_IDLE;
      paused_from       <= PH_IDLE;
      next_unsent       <= 16'd0;
      slots_in_batch    <= '0;
      control_retries   <= 8'd0;
      control_sent_time <= 32'd0;
      acked_total       <= 16'd0;
      batches_started   <= 16'd0;
      last_error        <= ERR_NONE;
      idx               <= '0;
      fill_count        <= '0;
      rd                <= '0;
    end else begin
      seq               <= seq_next;
      phase             <= phase_next;
      paused_from       <= paused_from_next;
      next_unsent       <= next_unsent_next;
      slots_in_batch    <= slots_in_batch_next;
      control_retries   <= control_retries_next;
      control_sent_time <= control_sent_time_next;
      acked_total       <= acked_total_next;
      batches_started   <= batches_started_next;
      last_error        <= last_error_next;
      idx               <= idx_next;
      fill_count        <= fill_count_next;
      rd                <= rd_next;
    end
  end

  // latched request, held for the whole execution
  always_ff @(posedge clk) begin
    if (req_fire) item <= req;
  end

  // response fields; an empty queue gives a single no-action response
  always_comb begin
    rsp.action        = (q_count == '0) ? ACT_NONE : rd_act;
    rsp.chunk_index   = (q_count != '0 && rd_act == ACT_DATA) ? rd_chunk : 16'd0;
    rsp.session_state = phase;
    rsp.error_code    = last_error;
    rsp.acked_count   = acked_total;
    rsp.batch_number  = batches_started;
    rsp.last          = rsp_last;
  end

endmodule
